FILE: sv/dhle_pkg.sv
// Package for the DNS host name label encoder.
// Holds the buffer sizing constants, command codes and the command type.
// No dependencies.
`timescale 1ns / 1ps

package dhle_pkg;

   localparam int LABEL_MAX = 32;
   localparam int CNT_W     = $clog2(LABEL_MAX + 1);
   localparam int ADDR_W    = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

   localparam logic [7:0] DOT_CHAR = 8'h2E;

   localparam logic [1:0] OP_STORE = 2'd0;
   localparam logic [1:0] OP_LABEL = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] ch;
   } cmd_type;

endpackage

FILE: sv/dhle_front.sv
// Front end of the label encoder: classifies each input transaction into a
// store, label or end command and queues it in a two-entry FIFO.
// Depends on dhle_pkg.
`timescale 1ns / 1ps

module dhle_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_ch,
   input  logic             req_is_end,
   output logic             cmd_valid,
   input  logic             cmd_stall,
   output dhle_pkg::cmd_type cmd
);
   import dhle_pkg::*;

   cmd_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   cmd_type    new_cmd;
   logic       push, pop;

   always_comb begin
      new_cmd.ch = req_ch;
      if (req_is_end) begin
         new_cmd.op = OP_END;
      end else if (req_ch == DOT_CHAR) begin
         new_cmd.op = OP_LABEL;
      end else begin
         new_cmd.op = OP_STORE;
      end
   end

   assign req_stall = (fill_ff == 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = cmd_valid && !cmd_stall;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

FILE: sv/dhle_back.sv
// Back end of the label encoder: holds the label buffer and replays it as
// a length byte, label bytes and, on end, terminator via output register.
// Depends on dhle_pkg.
`timescale 1ns / 1ps

module dhle_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_stall,
   input  dhle_pkg::cmd_type cmd,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_name_done,
   output logic              rsp_overflow
);
   import dhle_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LEN  = 2'd1;
   localparam logic [1:0] ST_BYTE = 2'd2;
   localparam logic [1:0] ST_TERM = 2'd3;

   logic [7:0]       store_mem [LABEL_MAX];
   logic [7:0]       rd_data_ff;
   logic             rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic             wr_en;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             ovf_ff, ovf_in;
   logic             end_ff, end_in;

   logic             out_free, load;
   logic [7:0]       load_byte;
   logic             load_done;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_done_ff, rsp_ovf_ff;
   logic [CNT_W-1:0] idx_next;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cmd_stall = (state_ff != ST_IDLE);
   assign idx_next  = idx_ff + CNT_W'(1);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      ovf_in    = ovf_ff;
      end_in    = end_ff;
      load      = 1'b0;
      load_byte = 8'd0;
      load_done = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == OP_STORE) begin
                  if (count_ff < CNT_W'(LABEL_MAX)) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  end_in   = (cmd.op == OP_END);
                  state_in = ST_LEN;
               end
            end
         end
         ST_LEN: begin
            if (out_free) begin
               load      = 1'b1;
               load_byte = 8'(count_ff);
               rd_en     = 1'b1;
               idx_in    = '0;
               if (count_ff == '0) begin
                  state_in = end_ff ? ST_TERM : ST_IDLE;
               end else begin
                  state_in = ST_BYTE;
               end
            end
         end
         ST_BYTE: begin
            if (out_free) begin
               load      = 1'b1;
               load_byte = rd_data_ff;
               rd_en     = 1'b1;
               rd_addr   = idx_next[ADDR_W-1:0];
               idx_in    = idx_next;
               if (idx_next == count_ff) begin
                  count_in = '0;
                  state_in = end_ff ? ST_TERM : ST_IDLE;
               end
            end
         end
         ST_TERM: begin
            if (out_free) begin
               load      = 1'b1;
               load_done = 1'b1;
               count_in  = '0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         ovf_ff       <= 1'b0;
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         end_ff   <= end_in;
         ovf_ff   <= (load && load_done) ? 1'b0 : ovf_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_byte_ff <= load_byte;
         rsp_done_ff <= load_done;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[count_ff[ADDR_W-1:0]] <= cmd.ch;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_name_done = rsp_done_ff;
   assign rsp_overflow  = rsp_ovf_ff;

endmodule

FILE: sv/dns_hostname_label_encoder.sv
// Top level of the DNS host name label encoder.
// Joins the classifying front end and the replaying back end; uses dhle_pkg.
//
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_ch[7:0], req_is_end
// rsp      out        rsp_valid/rsp_stall   rsp_out_byte[7:0], rsp_name_done, rsp_overflow
//
// A character transaction is written into the back end's label buffer unless it
// is full; a dot or end transaction starts a replay of one byte per cycle while
// the response is not stalled (length byte, label bytes, terminator on end).
// The front queue holds two commands, so at most two transactions are taken in
// during a replay before the input stalls.
// Reset is synchronous and clears the queue, counters and output valid.
// A stalled response holds its register; the back end waits with it.
`timescale 1ns / 1ps

module dns_hostname_label_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_is_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_name_done,
   output logic       rsp_overflow
);
   import dhle_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_stall;

   dhle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_ch     (req_ch),
      .req_is_end (req_is_end),
      .cmd_valid  (cmd_valid),
      .cmd_stall  (cmd_stall),
      .cmd        (cmd)
   );

   dhle_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd_stall     (cmd_stall),
      .cmd           (cmd),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_name_done (rsp_name_done),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

FILE: sv/dhle_checker.sv
// Port-level checker for the DNS host name label encoder, with its bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module dhle_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_ch,
   input logic       req_is_end,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_name_done,
   input logic       rsp_overflow
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_name_done) && $stable(rsp_overflow))
      else $error("Stalled response transaction changed.");

   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_name_done |-> rsp_out_byte == 8'd0)
      else $error("Terminator transaction carries a nonzero byte.");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_ch) && $stable(req_is_end))
      else $error("Stalled request transaction changed.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid after reset.");

endmodule

bind dns_hostname_label_encoder dhle_checker u_dhle_checker (.*);

FILE: bench/tb.sv
// Testbench for the DNS host name label encoder (dns_hostname_label_encoder).
// Drives host names one character per transaction and checks every encoded byte
// against its own label encoder prediction; uses dhle_pkg.
`timescale 1ns / 1ps

module tb;

   import dhle_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       name_done;
      logic       overflow;
   } qname_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_ch = 8'h00;
   logic       req_is_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_name_done;
   logic       rsp_overflow;

   logic [7:0]     label_buf [LABEL_MAX];
   int             label_len = 0;
   logic           overflow_flag = 1'b0;
   qname_byte_type qname_expected [$];

   int cycle_count = 0;
   int error_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int names_closed = 0;
   int overflow_names = 0;
   int burst_left = 0;

   dns_hostname_label_encoder i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ch        (req_ch),
      .req_is_end    (req_is_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_name_done (rsp_name_done),
      .rsp_overflow  (rsp_overflow)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: done, errors");
         $finish;
      end
   end

   // The receiver cycles through stall densities, including stretches with no stall.
   function automatic int stall_percent(input int cyc);
      case ((cyc / 160) % 5)
         0: return 0;
         1: return 30;
         2: return 0;
         3: return 70;
         default: return 92;
      endcase
   endfunction

   always @(posedge clock) begin
      qname_byte_type exp_byte;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (qname_expected.size() == 0) begin
            $error("unexpected transaction: out_byte %0h name_done %0b overflow %0b",
                   rsp_out_byte, rsp_name_done, rsp_overflow);
            error_count++;
         end else begin
            exp_byte = qname_expected.pop_front();
            checked_count++;
            if (rsp_out_byte !== exp_byte.out_byte) begin
               $error("out_byte: expected %0h, got %0h", exp_byte.out_byte, rsp_out_byte);
               error_count++;
            end
            if (rsp_name_done !== exp_byte.name_done) begin
               $error("name_done: expected %0b, got %0b", exp_byte.name_done, rsp_name_done);
               error_count++;
            end
            if (rsp_overflow !== exp_byte.overflow) begin
               $error("overflow: expected %0b, got %0b", exp_byte.overflow, rsp_overflow);
               error_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < stall_percent(cycle_count));
   end

   function automatic void push_label();
      qname_expected.push_back('{out_byte: 8'(label_len), name_done: 1'b0,
                                 overflow: overflow_flag});
      for (int i = 0; i < label_len; i++)
         qname_expected.push_back('{out_byte: label_buf[i], name_done: 1'b0,
                                    overflow: overflow_flag});
      label_len = 0;
   endfunction

   function automatic void encode_item(input logic [7:0] ch, input logic is_end);
      if (is_end) begin
         push_label();
         qname_expected.push_back('{out_byte: 8'h00, name_done: 1'b1,
                                    overflow: overflow_flag});
         names_closed++;
         if (overflow_flag)
            overflow_names++;
         overflow_flag = 1'b0;
      end else if (ch == DOT_CHAR) begin
         push_label();
      end else if (label_len < LABEL_MAX) begin
         label_buf[label_len] = ch;
         label_len++;
      end else begin
         overflow_flag = 1'b1;
      end
   endfunction

   task automatic send_item(input logic [7:0] ch, input logic is_end);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_ch     <= ch;
      req_is_end <= is_end;
      do @(posedge clock); while (req_stall);
      encode_item(ch, is_end);
      sent_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_item(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (qname_expected.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [7:0] label_char();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if (c == DOT_CHAR)
         c = 8'h2D;
      return c;
   endfunction

   function automatic int label_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(0, 6);
      else if (r < 92)
         return $urandom_range(7, LABEL_MAX - 1);
      return $urandom_range(LABEL_MAX - 2, LABEL_MAX + 6);
   endfunction

   task automatic test_basic_names();
      send_text("ab.c");
      send_end();
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'hFF, 1'b1);
      send_item(DOT_CHAR, 1'b1);
      wait_idle();
   endtask

   task automatic test_empty_labels();
      send_end();
      send_text(".x");
      send_end();
      send_text("a..b.");
      send_end();
      wait_idle();
   endtask

   task automatic test_label_limits();
      repeat (LABEL_MAX) send_item(label_char(), 1'b0);
      send_item(DOT_CHAR, 1'b0);
      repeat (LABEL_MAX + 2) send_item(label_char(), 1'b0);
      send_item(DOT_CHAR, 1'b0);
      send_text("q");
      send_end();
      send_text("z");
      send_end();
      wait_idle();
   endtask

   task automatic test_random_names(input int item_budget);
      int stop_at;
      int n_labels;
      int len;
      stop_at = sent_count + item_budget;
      while (sent_count < stop_at) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6))
               send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
         end else begin
            n_labels = $urandom_range(0, 4);
            for (int l = 0; l < n_labels; l++) begin
               len = label_length();
               repeat (len) send_item(label_char(), 1'b0);
               if (l < n_labels - 1 || $urandom_range(0, 7) == 0)
                  send_item(DOT_CHAR, 1'b0);
            end
            if ($urandom_range(0, 9) != 0)
               send_end();
         end
         if ($urandom_range(0, 39) == 0)
            wait_idle();
      end
      send_end();
      wait_idle();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_names();
      test_empty_labels();
      test_label_limits();
      test_random_names(320);
      repeat (20) @(posedge clock);
      $display("tb: %0d transactions sent, %0d encoded bytes checked", sent_count,
               checked_count);
      $display("tb: %0d names closed, %0d of them with dropped characters", names_closed,
               overflow_names);
      if (error_count == 0 && qname_expected.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
